// File: rtl/bitonic_sorter_macros.svh
// ----------------------------------------------------------------------------
// bitonic_sorter_macros.svh
// Assertion macros for the bitonic sorter, clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef BITONIC_SORTER_MACROS_SVH
`define BITONIC_SORTER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BS_ASSERT_IMP(name, ante, cons, msg)

`define BS_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

// File: rtl/bs_pkg.sv
// ----------------------------------------------------------------------------
// bs_pkg
// Widths, state codes and the signed compare shared by the bitonic sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package bs_pkg;

    localparam int MAX_WORDS = 64;
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int LOG_W     = $clog2(ADDR_W + 1);
    localparam int CFG_W     = 3;
    localparam int DATA_W    = 32;

    localparam logic [CFG_W-1:0] LOG_COUNT_RST = CFG_W'(6);

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_SORT = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    function automatic logic greater_signed(input logic signed [DATA_W-1:0] a,
                                            input logic signed [DATA_W-1:0] b);
        return a > b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bs_ram.sv
// ----------------------------------------------------------------------------
// bs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/bitonic_sorter.sv
// ----------------------------------------------------------------------------
// bitonic_sorter
// Block sorter: loads 2^log_count signed words, sorts them ascending with the
// bitonic network on one shared comparator, then streams them out in order.
// ----------------------------------------------------------------------------
// Usage:
//   log_count_we/log_count set the block size (sizes above 64 saturate);
//   a write drops any partly loaded block. Write only while idle.
//   Input: one word per request on value (in_valid/in_stall); in_stall is
//   low only while loading, so a block is taken at one word per cycle.
//   Output: value_res with last on the final word (out_valid/out_stall),
//   through one output register; out_stall holds it in place.
//   Per block of n = 2^L words, L > 0: n words are loaded, then sorted in
//     L(L+1)/2 stages of n/2 pairs, each stage followed by a drain of the
//     write-back, then emitted with one RAM read and one output load per
//     word.
//   The read, compare and write-back of each pair on the store set the
//   sort time.
//   A block of one word skips the sort.
//   Loading of the next block starts while the final word still waits.
//   Reset clears all control and sets log_count to 6; the store holds junk.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitonic_sorter_macros.svh"

module bitonic_sorter import bs_pkg::*; (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     log_count_we,
    input  wire logic [CFG_W-1:0]         log_count,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      value_res,
    output logic                          last
);

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   log_count_reg, log_count_next;
    logic [CNT_W-1:0]   load_cnt_reg, load_cnt_next;
    logic [LOG_W-1:0]   kl_reg, kl_next;
    logic [LOG_W-1:0]   jl_reg, jl_next;
    logic [ADDR_W-1:0]  q_reg, q_next;
    logic               hold_reg, hold_next;
    logic               done_reg, done_next;
    logic               s1_valid_reg, s1_valid_next;
    logic               s2_valid_reg, s2_valid_next;
    logic [ADDR_W-1:0]  emit_addr_reg, emit_addr_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               out_valid_reg, out_valid_next;

    logic [ADDR_W-1:0]  s1_i_reg;
    logic [ADDR_W-1:0]  s1_p_reg;
    logic               s1_up_reg;
    logic [ADDR_W-1:0]  s2_addr_reg;
    logic [DATA_W-1:0]  s2_data_reg;
    logic               rd_last_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic               out_last_reg;

    logic [LOG_W-1:0]   blk_log;
    logic [CNT_W-1:0]   blk_last;
    logic               blk_full;
    logic [ADDR_W-1:0]  pair_last;
    logic               in_take;
    logic               out_take;
    logic [ADDR_W-1:0]  low_mask;
    logic [ADDR_W-1:0]  pair_i;
    logic [ADDR_W-1:0]  pair_p;
    logic [ADDR_W:0]    pair_ix;
    logic               pair_up;
    logic               sort_issue;
    logic               stage_end;
    logic               wb_busy;
    logic               emit_issue;
    logic               emit_end;
    logic               swap;
    logic [DATA_W-1:0]  rd_a;
    logic [DATA_W-1:0]  rd_b;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr_a;

    assign blk_log   = (log_count_reg > CFG_W'(ADDR_W)) ? LOG_W'(ADDR_W)
                                                        : LOG_W'(log_count_reg);
    assign blk_last  = (CNT_W'(1) << blk_log) - CNT_W'(1);
    assign blk_full  = (load_cnt_reg == blk_last);
    assign pair_last = ADDR_W'(blk_last >> 1);

    assign in_stall = (state_reg != S_LOAD);
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    assign low_mask = (ADDR_W'(1) << jl_reg) - ADDR_W'(1);
    assign pair_i   = ((q_reg & ~low_mask) << 1) | (q_reg & low_mask);
    assign pair_p   = pair_i | (ADDR_W'(1) << jl_reg);
    assign pair_ix  = {1'b0, pair_i};
    assign pair_up  = ~pair_ix[kl_reg];

    assign sort_issue = (state_reg == S_SORT) && !done_reg && !s1_valid_reg
                        && !(hold_reg && s2_valid_reg);
    assign stage_end  = (q_reg == pair_last);
    assign wb_busy    = s1_valid_reg || s2_valid_reg;

    assign emit_issue = (state_reg == S_EMIT) && !rd_pend_reg
                        && (!out_valid_reg || out_take);
    assign emit_end   = (emit_addr_reg == blk_last[ADDR_W-1:0]);

    assign swap = (greater_signed(rd_a, rd_b) == s1_up_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = load_cnt_reg[ADDR_W-1:0];
        ram_wdata = value;
        if (in_take)
        begin
            ram_we = 1'b1;
        end
        else if (s1_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = s1_i_reg;
            ram_wdata = swap ? rd_b : rd_a;
        end
        else if (s2_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = s2_addr_reg;
            ram_wdata = s2_data_reg;
        end
    end

    assign ram_raddr_a = (state_reg == S_SORT) ? pair_i : emit_addr_reg;

    bs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WORDS)
    ) u_ram_a (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr_a),
        .rdata (rd_a)
    );

    bs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WORDS)
    ) u_ram_b (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (pair_p),
        .rdata (rd_b)
    );

    always_comb
    begin
        state_next     = state_reg;
        log_count_next = log_count_reg;
        load_cnt_next  = load_cnt_reg;
        kl_next        = kl_reg;
        jl_next        = jl_reg;
        q_next         = q_reg;
        hold_next      = hold_reg;
        done_next      = done_reg;
        s1_valid_next  = sort_issue;
        s2_valid_next  = s1_valid_reg;
        emit_addr_next = emit_addr_reg;
        rd_pend_next   = emit_issue;
        out_valid_next = out_valid_reg;

        if (log_count_we)
        begin
            log_count_next = log_count;
            load_cnt_next  = '0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_take)
                begin
                    if (blk_full)
                    begin
                        load_cnt_next = '0;
                        kl_next       = LOG_W'(1);
                        jl_next       = '0;
                        q_next        = '0;
                        hold_next     = 1'b0;
                        done_next     = 1'b0;
                        emit_addr_next = '0;
                        state_next    = (blk_log == '0) ? S_EMIT : S_SORT;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + CNT_W'(1);
                    end
                end
            end
            S_SORT:
            begin
                if (sort_issue)
                begin
                    hold_next = stage_end;
                    if (stage_end)
                    begin
                        q_next = '0;
                        if (jl_reg == '0)
                        begin
                            if (kl_reg == blk_log)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                kl_next = kl_reg + LOG_W'(1);
                                jl_next = kl_reg;
                            end
                        end
                        else
                        begin
                            jl_next = jl_reg - LOG_W'(1);
                        end
                    end
                    else
                    begin
                        q_next = q_reg + ADDR_W'(1);
                    end
                end
                else if (done_reg && !wb_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_issue)
                begin
                    emit_addr_next = emit_addr_reg + ADDR_W'(1);
                    if (emit_end)
                    begin
                        emit_addr_next = '0;
                        state_next     = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (rd_pend_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            log_count_reg <= LOG_COUNT_RST;
            load_cnt_reg  <= '0;
            kl_reg        <= '0;
            jl_reg        <= '0;
            q_reg         <= '0;
            hold_reg      <= 1'b0;
            done_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            emit_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            log_count_reg <= log_count_next;
            load_cnt_reg  <= load_cnt_next;
            kl_reg        <= kl_next;
            jl_reg        <= jl_next;
            q_reg         <= q_next;
            hold_reg      <= hold_next;
            done_reg      <= done_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            emit_addr_reg <= emit_addr_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sort_issue)
        begin
            s1_i_reg  <= pair_i;
            s1_p_reg  <= pair_p;
            s1_up_reg <= pair_up;
        end
        if (s1_valid_reg)
        begin
            s2_addr_reg <= s1_p_reg;
            s2_data_reg <= swap ? rd_a : rd_b;
        end
        if (emit_issue)
        begin
            rd_last_reg <= emit_end;
        end
        if (rd_pend_reg)
        begin
            out_data_reg <= rd_a;
            out_last_reg <= rd_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_res = out_data_reg;
    assign last      = out_last_reg;

    `BS_ASSERT_IMP(a_rd_free, rd_pend_reg, !out_valid_reg, "read into a full output register")
    `BS_ASSERT_IMP(a_wr_excl, s2_valid_reg, !s1_valid_reg, "two write-backs in one cycle")
    `BS_ASSERT_IMP(a_emit_clean, state_reg == S_EMIT, !wb_busy, "write-back pending during emit")
    `BS_ASSERT_NXT(a_load_stall, in_take && blk_full && |blk_log, in_stall, "input taken in sort")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Block sort check for bitonic_sorter. Words are sent in blocks at several
// block sizes, including one word, the full 64 and a saturated size, and a
// partly loaded block dropped by a size write. Each finished block is sorted
// here with the same bitonic network, and every word that leaves the block is
// compared in order with the prediction, last flag included. Both sides stall
// at random, and one long output hold-off fills the block up.
// ----------------------------------------------------------------------------
module tb;
    import bs_pkg::*;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t WORD_MIN      = {1'b1, {(DATA_W-1){1'b0}}};
    localparam word_t WORD_MAX      = {1'b0, {(DATA_W-1){1'b1}}};
    localparam int    SETTLE_CYCLES = 16;
    localparam int    HOLD_CYCLES   = 300;
    localparam int    CYCLE_LIMIT   = 200000;
    localparam int    REPORT_LIMIT  = 10;

    class sort_scoreboard;
        word_t            block_words[MAX_WORDS];
        int unsigned      loaded;
        logic [CFG_W-1:0] size_log;
        word_t            sorted_words[$];
        bit               last_flags[$];
        int unsigned      mismatches;

        function new();
            loaded     = 0;
            size_log   = LOG_COUNT_RST;
            mismatches = 0;
        endfunction

        function void set_size(input logic [CFG_W-1:0] lg);
            size_log = lg;
            loaded   = 0;
        endfunction

        function int unsigned pending();
            return sorted_words.size();
        endfunction

        function int unsigned block_len();
            int unsigned n;
            n = 1 << size_log;
            return (n > MAX_WORDS) ? MAX_WORDS : n;
        endfunction

        function void sort_block(input int unsigned n);
            int unsigned k;
            int unsigned j;
            int unsigned i;
            int unsigned p;
            word_t       t;
            for (k = 2; k <= n; k <<= 1)
            begin
                for (j = k >> 1; j > 0; j >>= 1)
                begin
                    for (i = 0; i < n; i++)
                    begin
                        p = i ^ j;
                        if (p > i && p < n &&
                            ((block_words[i] > block_words[p]) == ((i & k) == 0)))
                        begin
                            t              = block_words[i];
                            block_words[i] = block_words[p];
                            block_words[p] = t;
                        end
                    end
                end
            end
        endfunction

        function void note_request(input word_t w);
            int unsigned n;
            int unsigned i;
            n = block_len();
            if (loaded >= n)
                loaded = 0;
            block_words[loaded] = w;
            loaded++;
            if (loaded == n)
            begin
                sort_block(n);
                for (i = 0; i < n; i++)
                begin
                    sorted_words.push_back(block_words[i]);
                    last_flags.push_back(i + 1 == n);
                end
                loaded = 0;
            end
        endfunction

        function void check_result(input word_t w, input logic lst);
            word_t want;
            bit    want_last;
            if (sorted_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result with nothing pending: value %0d last %0b", w, lst);
                return;
            end
            want      = sorted_words.pop_front();
            want_last = last_flags.pop_front();
            if (w !== want || lst !== want_last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: value %0d last %0b, wanted value %0d last %0b",
                             w, lst, want, want_last);
            end
        endfunction
    endclass

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             log_count_we = 1'b0;
    logic [CFG_W-1:0] log_count    = '0;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    word_t            word_in      = '0;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    word_t            word_out;
    logic             word_last;

    int unsigned      send_idle_pct  = 22;
    int unsigned      recv_stall_pct = 56;
    bit               hold_armed     = 1'b0;
    int unsigned      hold_left      = 0;
    int unsigned      cycles         = 0;
    sort_scoreboard   sb             = new();

    bitonic_sorter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .log_count_we (log_count_we),
        .log_count    (log_count),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (word_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value_res    (word_out),
        .last         (word_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(word_out, word_last);
    end

    // hold off the output for a long stretch once armed
    always @(negedge clk)
    begin
        if (hold_armed)
        begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    function automatic word_t pick_word();
        case ($urandom_range(7, 0))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2, 3:    return word_t'(int'($urandom_range(8, 0)) - 4);
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic void fill_batch(ref word_t batch[$], input int unsigned count);
        batch.delete();
        repeat (count)
            batch.push_back(pick_word());
    endfunction

    task automatic write_size(input logic [CFG_W-1:0] lg);
        log_count_we <= 1'b1;
        log_count    <= lg;
        @(negedge clk);
        log_count_we <= 1'b0;
        sb.set_size(lg);
    endtask

    task automatic send_word(input word_t w);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        word_in  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(w);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic list_phase(input logic [CFG_W-1:0] lg, input word_t batch[$]);
        write_size(lg);
        foreach (batch[i])
            send_word(batch[i]);
        drain();
    endtask

    task automatic random_phases(input int unsigned target);
        int unsigned tally;
        int unsigned lg;
        int unsigned n;
        int unsigned words;
        word_t       batch[$];
        tally = 0;
        while (tally < target)
        begin
            lg    = ($urandom_range(3, 0) == 0) ? $urandom_range(5, 3) : $urandom_range(2, 0);
            n     = 1 << lg;
            words = n * $urandom_range((n <= 4) ? 4 : 1, 1);
            if (n > 1 && $urandom_range(3, 0) == 0)
                words += $urandom_range(n - 1, 1);
            fill_batch(batch, words);
            list_phase(CFG_W'(lg), batch);
            tally += words;
        end
    endtask

    initial
    begin
        word_t batch[$];
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        batch = '{WORD_MIN, WORD_MAX, 0, -1};
        list_phase(CFG_W'(0), batch);
        batch = '{WORD_MAX, WORD_MIN};
        list_phase(CFG_W'(1), batch);
        batch = '{3, WORD_MIN, 3, -1};
        list_phase(CFG_W'(2), batch);
        // drop the partial block with the next write
        batch = '{5, -5, 9};
        list_phase(CFG_W'(3), batch);
        batch = '{WORD_MAX, 100, -100, 0, WORD_MIN, 100, -1, 1};
        list_phase(CFG_W'(3), batch);

        fill_batch(batch, MAX_WORDS);
        list_phase(CFG_W'(7), batch);

        send_idle_pct  = 56;
        recv_stall_pct = 22;
        fill_batch(batch, 6);
        list_phase(CFG_W'(6), batch);
        random_phases(8);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_armed     = 1'b1;
        fill_batch(batch, 12);
        list_phase(CFG_W'(2), batch);
        random_phases(8);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
